FILE: sv/chfm_pkg.sv
`timescale 1ns / 1ps
// chfm_pkg: types, constants and shared functions for the cluster hit filter and merge block.
// No dependencies.
package chfm_pkg;

  localparam int MAX_RES = 64;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 17;

  localparam logic [4:0] FL_DOUBLE  = 5'h01;
  localparam logic [4:0] FL_DEAD    = 5'h02;
  localparam logic [4:0] FL_ONEPAD  = 5'h04;
  localparam logic [4:0] FL_ROWEDGE = 5'h08;
  localparam logic [4:0] FL_BROKEN  = 5'h10;

  localparam logic [15:0] MIN_CHARGE  = 16'd40;
  localparam logic [16:0] MIN_TLEN    = 17'sd3;
  localparam logic [14:0] MERGE_WIN   = 15'd128;

  typedef enum logic [2:0] {
    CFG_MERGE_EN = 3'd0,
    CFG_CUTS_EN  = 3'd1,
    CFG_SWAP     = 3'd2,
    CFG_EDGE_A   = 3'd3,
    CFG_EDGE_B0  = 3'd4,
    CFG_EDGE_B1  = 3'd5,
    CFG_EDGE_C   = 3'd6
  } chfm_cfg_idx_t;

  typedef struct packed {
    logic       merge_en;
    logic       cuts_en;
    logic       swap;
    logic [7:0] edge_a;
    logic [7:0] edge_b0;
    logic [7:0] edge_b1;
    logic [7:0] edge_c;
  } chfm_cfg_t;

  typedef struct packed {
    logic        func;
    logic [31:0] packed_position;
    logic [31:0] packed_charge_flags;
  } chfm_in_t;

  typedef struct packed {
    logic [13:0] pad_pos;
    logic [14:0] time_pos;
    logic [15:0] charge;
    logic [4:0]  flags;
    logic [15:0] pad_low;
    logic [15:0] pad_high;
    logic [15:0] time_low;
    logic [15:0] time_high;
    logic        last;
  } chfm_out_t;

  typedef struct packed {
    logic [13:0] pad;
    logic [14:0] tm;
    logic [15:0] c;
    logic [4:0]  f;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] t1;
    logic [15:0] t2;
  } chfm_hit_t;

  typedef enum logic [1:0] {
    K_EMIT  = 2'd0,
    K_STORE = 2'd1,
    K_FLUSH = 2'd2
  } chfm_kind_t;

  typedef struct packed {
    chfm_kind_t kind;
    logic [1:0] lst;
    chfm_hit_t  hit;
  } chfm_item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_M_RDA,
    B_M_GETA,
    B_M_RDB,
    B_M_GETB,
    B_M_MUL1,
    B_M_MUL2,
    B_M_MUL3,
    B_M_DIVT,
    B_M_DIVP,
    B_M_WRA,
    B_E_RD,
    B_E_GET,
    B_E_END
  } chfm_bstate_t;

  function automatic logic passes(input chfm_hit_t h, input logic cuts_en);
    logic signed [16:0] dt;
    logic ok;
    dt = $signed({1'b0, h.t2}) - $signed({1'b0, h.t1});
    ok = 1'b1;
    if (cuts_en) begin
      if ((h.f & (FL_ONEPAD | FL_ROWEDGE | FL_DEAD)) != 5'd0) ok = 1'b0;
      if (dt <= $signed(MIN_TLEN)) ok = 1'b0;
      if (h.t1 == 16'd0) ok = 1'b0;
      if (h.c < MIN_CHARGE) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

FILE: sv/cluster_hit_filter_and_merge.sv
`timescale 1ns / 1ps
// cluster_hit_filter_and_merge: top level, configuration registers, front and back ends.
// Depends on chfm_pkg, chfm_front, chfm_back.
//
// A hit transaction is queued (two entries) unless the filter drops it; the back end
// takes one queued hit per cycle while idle, so hits sustain one per cycle while
// busy stays low. An end-of-row transaction walks the lists through one RAM,
// and each merge adds three multiply steps and two divisions; the flush then reads
// every stored entry. If edge_a is zero, the lists are cleared with no merge or
// flush. busy rises while the queue is full. Results appear on out_valid for one
// cycle each and cannot be held off. Configuration writes are taken at once
// (cfg_ready is always high).
module cluster_hit_filter_and_merge #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  chfm_pkg::chfm_in_t  in_data,
  output logic                out_valid,
  output chfm_pkg::chfm_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import chfm_pkg::*;

  chfm_cfg_t  cfg_r;
  chfm_item_t q_item;
  logic       q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.merge_en <= 1'b1;
      cfg_r.cuts_en  <= 1'b1;
      cfg_r.swap     <= 1'b0;
      cfg_r.edge_a   <= '0;
      cfg_r.edge_b0  <= '0;
      cfg_r.edge_b1  <= '0;
      cfg_r.edge_c   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (chfm_cfg_idx_t'(cfg_index))
        CFG_MERGE_EN: cfg_r.merge_en <= cfg_data[0];
        CFG_CUTS_EN:  cfg_r.cuts_en  <= cfg_data[0];
        CFG_SWAP:     cfg_r.swap     <= cfg_data[0];
        CFG_EDGE_A:   cfg_r.edge_a   <= cfg_data;
        CFG_EDGE_B0:  cfg_r.edge_b0  <= cfg_data;
        CFG_EDGE_B1:  cfg_r.edge_b1  <= cfg_data;
        CFG_EDGE_C:   cfg_r.edge_c   <= cfg_data;
        default: ;
      endcase
    end
  end

  chfm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  chfm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sv/chfm_ram.sv
`timescale 1ns / 1ps
// chfm_ram: generic single write, single read RAM with registered read data.
// No dependencies.
module chfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/chfm_div.sv
`timescale 1ns / 1ps
// chfm_div: restoring divider, one quotient bit per cycle.
// Depends on chfm_pkg.
module chfm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [chfm_pkg::NUM_W-1:0] num,
  input  logic [chfm_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [chfm_pkg::NUM_W-1:0] quot
);
  import chfm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, q_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign done   = done_r;
  assign quot   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
    end
  end

endmodule

FILE: sv/chfm_front.sv
`timescale 1ns / 1ps
// chfm_front: unpack and classify input transactions, queue them for the back end.
// Depends on chfm_pkg.
module chfm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  chfm_pkg::chfm_cfg_t  cfg,
  input  logic                 start,
  output logic                 busy,
  input  chfm_pkg::chfm_in_t   in_data,
  output logic                 q_valid,
  output chfm_pkg::chfm_item_t q_item,
  input  logic                 q_pop
);
  import chfm_pkg::*;

  function automatic logic [31:0] bswap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  logic [31:0] pt, cf;
  chfm_hit_t   h;
  chfm_item_t  item;
  logic        push, acc;

  chfm_item_t  q_mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  always_comb begin
    pt = cfg.swap ? bswap(in_data.packed_position) : in_data.packed_position;
    cf = cfg.swap ? bswap(in_data.packed_charge_flags) : in_data.packed_charge_flags;
    h.tm  = pt[30:16];
    h.pad = pt[13:0];
    h.c   = cf[31:16];
    h.f   = '0;
    if (pt[15]) h.f = h.f | FL_DOUBLE;
    if (pt[14]) h.f = h.f | FL_DEAD;
    if (pt[31]) h.f = h.f | FL_ONEPAD;
    if (cf[15]) h.f = h.f | FL_ROWEDGE;
    if (cf[14]) h.f = h.f | FL_BROKEN;
    h.t2 = 16'(pt[30:22]) + 16'(cf[7:4]);
    h.t1 = 16'(pt[30:22]) - 16'(cf[3:0]);
    h.p2 = 16'(pt[13:6]) + 16'(cf[13:11]);
    h.p1 = 16'(pt[13:6]) - 16'(cf[10:8]);

    item.hit  = h;
    item.lst  = 2'd0;
    item.kind = K_EMIT;
    push      = 1'b0;
    if (in_data.func) begin
      item.kind = K_FLUSH;
      push      = 1'b1;
    end else if (cfg.merge_en && ((h.f & FL_BROKEN) != 5'd0)) begin
      item.kind = K_STORE;
      push      = 1'b1;
      if (h.p2 == 16'(cfg.edge_a)) item.lst = 2'd0;
      else if (h.p1 == 16'(cfg.edge_b0)) item.lst = 2'd1;
      else if (h.p2 == 16'(cfg.edge_b1)) item.lst = 2'd2;
      else if (h.p1 == 16'(cfg.edge_c)) item.lst = 2'd3;
      else push = 1'b0;
    end else begin
      push = passes(h, cfg.cuts_en);
    end
  end

  assign busy    = cnt_r == 2'd2;
  assign acc     = start && !busy && push;
  assign q_valid = cnt_r != 2'd0;
  assign q_item  = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (acc) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(acc) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q_mem_r[wp_r] <= item;
  end

endmodule

FILE: sv/chfm_back.sv
`timescale 1ns / 1ps
// chfm_back: emit, list store, end-of-row merge and flush sequencer.
// Depends on chfm_pkg, chfm_ram, chfm_div.
module chfm_back #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  chfm_pkg::chfm_cfg_t  cfg,
  input  logic                 q_valid,
  input  chfm_pkg::chfm_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  output chfm_pkg::chfm_out_t  out_data
);
  import chfm_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(4 * LIST_DEPTH);
  localparam int HW = $bits(chfm_hit_t);
  localparam int NW = $clog2(MAX_RES + 1);

  function automatic logic [AW-1:0] addr(input logic [1:0] l, input logic [CW-1:0] i);
    return AW'(AW'(l) * AW'(LIST_DEPTH) + AW'(i));
  endfunction

  function automatic chfm_out_t to_out(input chfm_hit_t h, input logic last);
    chfm_out_t o;
    o.pad_pos   = h.pad;
    o.time_pos  = h.tm;
    o.charge    = h.c;
    o.flags     = h.f;
    o.pad_low   = h.p1;
    o.pad_high  = h.p2;
    o.time_low  = h.t1;
    o.time_high = h.t2;
    o.last      = last;
    return o;
  endfunction

  chfm_bstate_t state_r, state_nxt;
  logic         rl_r, rl_nxt;
  logic [1:0]   l_r, l_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] cnt_r [4];
  logic [CW-1:0] cnt_nxt [4];
  logic [NW-1:0] n_r, n_nxt;
  logic         have_r, have_nxt;
  logic         out_valid_r, out_valid_nxt;
  chfm_out_t    out_r, out_nxt;

  chfm_hit_t    a_r, a_nxt, b_r, b_nxt, pend_r, pend_nxt, rd_hit, wb;
  logic [DEN_W-1:0] sum_r, sum_nxt, sum_c;
  logic [NUM_W-1:0] pa_r, pa_nxt, pb_r, pb_nxt, num_r, num_nxt;
  logic [14:0]  qt_r, qt_nxt, dt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [HW-1:0] wr_data, rd_data;
  logic          div_start, div_done;
  logic [NUM_W-1:0] div_q;
  logic [1:0]    lb, la;

  chfm_ram #(.WIDTH(HW), .DEPTH(4 * LIST_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  chfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (sum_r),
    .done  (div_done),
    .quot  (div_q)
  );

  assign rd_hit    = chfm_hit_t'(rd_data);
  assign la        = {rl_r, 1'b0};
  assign lb        = {rl_r, 1'b1};
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    rl_nxt        = rl_r;
    l_nxt         = l_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    have_nxt      = have_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    pend_nxt      = pend_r;
    sum_nxt       = sum_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    num_nxt       = num_r;
    qt_nxt        = qt_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = addr(la, i_r);
    wr_data       = HW'(a_r);
    rd_en         = 1'b0;
    rd_addr       = addr(la, i_r);
    div_start     = 1'b0;
    wb            = rd_hit;
    sum_c         = DEN_W'(a_r.c) + DEN_W'(rd_hit.c);
    dt            = (a_r.tm > rd_hit.tm) ? a_r.tm - rd_hit.tm : rd_hit.tm - a_r.tm;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            K_EMIT: begin
              out_valid_nxt = 1'b1;
              out_nxt       = to_out(q_item.hit, 1'b0);
            end
            K_STORE: begin
              if (cnt_r[q_item.lst] < CW'(LIST_DEPTH)) begin
                wr_en   = 1'b1;
                wr_addr = addr(q_item.lst, cnt_r[q_item.lst]);
                wr_data = HW'(q_item.hit);
                cnt_nxt[q_item.lst] = cnt_r[q_item.lst] + 1'b1;
              end
            end
            K_FLUSH: begin
              rl_nxt = 1'b0;
              i_nxt  = '0;
              if (cfg.edge_a != 8'd0) begin
                state_nxt = B_M_RDA;
              end else begin
                for (int k = 0; k < 4; k++) cnt_nxt[k] = '0;
              end
            end
            default: ;
          endcase
        end
      end
      B_M_RDA: begin
        if (i_r < cnt_r[la]) begin
          rd_en     = 1'b1;
          rd_addr   = addr(la, i_r);
          j_nxt     = '0;
          state_nxt = B_M_GETA;
        end else if (!rl_r) begin
          rl_nxt = 1'b1;
          i_nxt  = '0;
        end else begin
          l_nxt     = 2'd0;
          i_nxt     = '0;
          n_nxt     = '0;
          have_nxt  = 1'b0;
          state_nxt = B_E_RD;
        end
      end
      B_M_GETA: begin
        a_nxt     = rd_hit;
        state_nxt = B_M_RDB;
      end
      B_M_RDB: begin
        if (j_r < cnt_r[lb]) begin
          rd_en     = 1'b1;
          rd_addr   = addr(lb, j_r);
          state_nxt = B_M_GETB;
        end else begin
          state_nxt = B_M_WRA;
        end
      end
      B_M_GETB: begin
        b_nxt = rd_hit;
        if (rd_hit.c == 16'd0 || dt >= MERGE_WIN) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = B_M_RDB;
        end else if (sum_c[DEN_W-1]) begin
          a_nxt.c   = '0;
          wb.c      = '0;
          wr_en     = 1'b1;
          wr_addr   = addr(lb, j_r);
          wr_data   = HW'(wb);
          j_nxt     = j_r + 1'b1;
          state_nxt = B_M_RDB;
        end else begin
          sum_nxt   = sum_c;
          state_nxt = B_M_MUL1;
        end
      end
      B_M_MUL1: begin
        pa_nxt    = NUM_W'(a_r.tm * a_r.c);
        pb_nxt    = NUM_W'(b_r.tm * b_r.c);
        state_nxt = B_M_MUL2;
      end
      B_M_MUL2: begin
        num_nxt   = pa_r + pb_r;
        pa_nxt    = NUM_W'(a_r.pad * a_r.c);
        pb_nxt    = NUM_W'(b_r.pad * b_r.c);
        state_nxt = B_M_MUL3;
      end
      B_M_MUL3: begin
        div_start = 1'b1;
        num_nxt   = pa_r + pb_r;
        state_nxt = B_M_DIVT;
      end
      B_M_DIVT: begin
        if (div_done) begin
          qt_nxt    = div_q[14:0];
          div_start = 1'b1;
          state_nxt = B_M_DIVP;
        end
      end
      B_M_DIVP: begin
        if (div_done) begin
          a_nxt.tm  = qt_r;
          a_nxt.pad = div_q[13:0];
          a_nxt.c   = sum_r[15:0];
          a_nxt.f   = (a_r.f | b_r.f) & ~FL_ONEPAD;
          a_nxt.p2  = b_r.p2;
          if (b_r.t2 > a_r.t2) a_nxt.t2 = b_r.t2;
          if (b_r.t1 < a_r.t1) a_nxt.t1 = b_r.t1;
          wb        = b_r;
          wb.c      = '0;
          wr_en     = 1'b1;
          wr_addr   = addr(lb, j_r);
          wr_data   = HW'(wb);
          state_nxt = B_M_WRA;
        end
      end
      B_M_WRA: begin
        wr_en     = 1'b1;
        wr_addr   = addr(la, i_r);
        wr_data   = HW'(a_r);
        i_nxt     = i_r + 1'b1;
        state_nxt = B_M_RDA;
      end
      B_E_RD: begin
        if (i_r < cnt_r[l_r]) begin
          rd_en     = 1'b1;
          rd_addr   = addr(l_r, i_r);
          state_nxt = B_E_GET;
        end else if (l_r != 2'd3) begin
          l_nxt = l_r + 1'b1;
          i_nxt = '0;
        end else begin
          state_nxt = B_E_END;
        end
      end
      B_E_GET: begin
        i_nxt     = i_r + 1'b1;
        state_nxt = B_E_RD;
        if (passes(rd_hit, cfg.cuts_en) && n_r < NW'(MAX_RES)) begin
          if (have_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = to_out(pend_r, 1'b0);
          end
          pend_nxt = rd_hit;
          have_nxt = 1'b1;
          n_nxt    = n_r + 1'b1;
        end
      end
      B_E_END: begin
        if (have_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = to_out(pend_r, 1'b1);
        end
        have_nxt = 1'b0;
        for (int k = 0; k < 4; k++) cnt_nxt[k] = '0;
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rl_r        <= 1'b0;
      l_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
    end else begin
      state_r     <= state_nxt;
      rl_r        <= rl_nxt;
      l_r         <= l_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      n_r         <= n_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    pend_r <= pend_nxt;
    sum_r  <= sum_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    num_r  <= num_nxt;
    qt_r   <= qt_nxt;
  end

endmodule

FILE: sv/chfm_chk.sv
`timescale 1ns / 1ps
// chfm_chk: port-level checks of cluster_hit_filter_and_merge, bound to the top level.
// Depends on chfm_pkg.
module chfm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                busy,
  input logic                out_valid,
  input chfm_pkg::chfm_out_t out_data,
  input logic                cfg_ready
);

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration channel stalled");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("unknown bits in result transaction");

endmodule

bind cluster_hit_filter_and_merge chfm_chk u_chk (.*);
